@@ rtl/core/rsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rsfe_pkg
// Shared constants, codes and types of the RMC sentence field extractor.
// ----------------------------------------------------------------------------
package rsfe_pkg;

  // Store sizes.
  localparam int TIME_LEN  = 6;
  localparam int COORD_LEN = 14;

  // Layout of the single field memory: time, status, latitude, longitude.
  localparam int STATUS_ADDR = TIME_LEN;
  localparam int LAT_BASE    = TIME_LEN + 1;
  localparam int LON_BASE    = LAT_BASE + COORD_LEN;
  localparam int MEM_DEPTH   = LON_BASE + COORD_LEN;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  // Fill index must be able to hold the longest store length itself.
  localparam int MAX_LEN = (TIME_LEN > COORD_LEN) ? TIME_LEN : COORD_LEN;
  localparam int FILL_W  = $clog2(MAX_LEN + 1);

  // Character codes.
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  // Register reset values and indexes.
  localparam logic [7:0] TYPE_KEY_RESET = CH_M + CH_C;
  localparam logic [7:0] END_CHAR_RESET = 8'h0D;
  localparam logic       REG_TYPE_KEY   = 1'b0;
  localparam logic       REG_END_CHAR   = 1'b1;

  // Field identifiers on the result channel.
  localparam logic [1:0] FIELD_TIME   = 2'd0;
  localparam logic [1:0] FIELD_STATUS = 2'd1;
  localparam logic [1:0] FIELD_LAT    = 2'd2;
  localparam logic [1:0] FIELD_LON    = 2'd3;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

@@ rtl/core/rsfe_cfg.sv @@
// ----------------------------------------------------------------------------
// rsfe_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module rsfe_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [7:0]  type_key,
  output logic [7:0]  end_char
);
  import rsfe_pkg::*;

  logic wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_key <= TYPE_KEY_RESET;
      end_char <= END_CHAR_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_TYPE_KEY: type_key <= pwdata[7:0];
        REG_END_CHAR: end_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TYPE_KEY: prdata = {24'd0, type_key};
      REG_END_CHAR: prdata = {24'd0, end_char};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/rsfe_store_mem.sv @@
// ----------------------------------------------------------------------------
// rsfe_store_mem
// Field memory with one write port, one registered read port and a valid
// bit per entry, so that entries never written read as zero.
// ----------------------------------------------------------------------------
module rsfe_store_mem (
  input  logic             clk,
  input  logic             rst,
  input  rsfe_pkg::mem_wr_t wr,
  input  rsfe_pkg::mem_rd_t rd,
  output logic [7:0]       rdata
);
  import rsfe_pkg::*;

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] written;
  logic [7:0]           rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata_q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rvalid_q <= written[rd.addr];
      end
    end
  end

  assign rdata = rvalid_q ? rdata_q : 8'd0;

endmodule

@@ rtl/core/rsfe_parser.sv @@
// ----------------------------------------------------------------------------
// rsfe_parser
// Sentence tracking: position, type sum, comma count and fill index. Turns
// each accepted character into at most one memory write and flags the end
// of a sentence.
// ----------------------------------------------------------------------------
module rsfe_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_in,
  input  logic [7:0]        type_key,
  input  logic [7:0]        end_char,
  output rsfe_pkg::mem_wr_t wr,
  output logic              dump_start
);
  import rsfe_pkg::*;

  logic              in_sentence;
  logic [2:0]        char_position;
  logic [7:0]        type_sum;
  logic [2:0]        comma_count;
  logic [FILL_W-1:0] fill_index;

  logic              capture;
  logic [2:0]        comma_count_next;
  logic [FILL_W-1:0] fill_index_next;
  logic              to_time, to_status, to_lat, to_lon, fill_clear;
  logic              time_room, coord_room;
  logic              sentence_end;

  always_comb begin
    capture    = in_sentence && (type_sum == type_key);
    to_time    = 1'b0;
    to_status  = 1'b0;
    to_lat     = 1'b0;
    to_lon     = 1'b0;
    fill_clear = 1'b0;
    comma_count_next = comma_count;

    if (capture) begin
      if (char_in == CH_COMMA) begin
        comma_count_next = comma_count + 3'd1;
        // The commas before each hemisphere are part of the coordinate.
        if (comma_count_next == 3'd4) begin
          to_lat = 1'b1;
        end else if (comma_count_next == 3'd6) begin
          to_lon = 1'b1;
        end else begin
          fill_clear = 1'b1;
        end
      end else begin
        case (comma_count)
          3'd1:       to_time   = 1'b1;
          3'd2:       to_status = 1'b1;
          3'd3, 3'd4: to_lat    = 1'b1;
          3'd5, 3'd6: to_lon    = 1'b1;
          default:    ;
        endcase
      end
    end

    time_room  = fill_index < FILL_W'(TIME_LEN);
    coord_room = fill_index < FILL_W'(COORD_LEN);

    wr.data = char_in;
    wr.en   = accept && (to_status || (to_time && time_room) ||
                         ((to_lat || to_lon) && coord_room));
    if (to_time) begin
      wr.addr = ADDR_W'(fill_index);
    end else if (to_lat) begin
      wr.addr = ADDR_W'(LAT_BASE) + ADDR_W'(fill_index);
    end else if (to_lon) begin
      wr.addr = ADDR_W'(LON_BASE) + ADDR_W'(fill_index);
    end else begin
      wr.addr = ADDR_W'(STATUS_ADDR);
    end

    if (fill_clear) begin
      fill_index_next = '0;
    end else if ((to_time && time_room) || ((to_lat || to_lon) && coord_room)) begin
      fill_index_next = fill_index + FILL_W'(1);
    end else begin
      fill_index_next = fill_index;
    end

    sentence_end = in_sentence &&
                   ((char_in == end_char) || (comma_count_next == 3'd7));
    dump_start   = accept && sentence_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence   <= 1'b0;
      char_position <= 3'd0;
      type_sum      <= 8'd0;
      comma_count   <= 3'd0;
      fill_index    <= '0;
    end else if (accept) begin
      if (!in_sentence) begin
        if (char_in == CH_DOLLAR) begin
          in_sentence <= 1'b1;
          if (char_position != 3'd7) begin
            char_position <= char_position + 3'd1;
          end
        end
      end else begin
        fill_index <= fill_index_next;
        if (sentence_end) begin
          in_sentence   <= 1'b0;
          char_position <= 3'd0;
          type_sum      <= 8'd0;
          comma_count   <= 3'd0;
        end else begin
          comma_count <= comma_count_next;
          if (char_position == 3'd4 || char_position == 3'd5) begin
            type_sum <= type_sum + char_in;
          end
          if (char_position != 3'd7) begin
            char_position <= char_position + 3'd1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/core/rsfe_dump.sv @@
// ----------------------------------------------------------------------------
// rsfe_dump
// Walks the field memory at the end of a sentence and presents one result
// beat per entry through an output register.
// ----------------------------------------------------------------------------
module rsfe_dump (
  input  logic              clk,
  input  logic              rst,
  input  logic              dump_start,
  output rsfe_pkg::mem_rd_t rd,
  input  logic [7:0]        rdata,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        field_id,
  output logic [3:0]        byte_pos,
  output logic [7:0]        char_value,
  output logic              last
);
  import rsfe_pkg::*;

  logic              running;
  logic              pending;
  logic [ADDR_W-1:0] cur_addr;
  logic [1:0]        cur_field;
  logic [FILL_W-1:0] cur_pos;
  logic              cur_last;
  logic [1:0]        pend_field;
  logic [FILL_W-1:0] pend_pos;
  logic              pend_last;
  logic              issue;

  // One read in flight at a time; it is only issued when the output
  // register is guaranteed to be empty when its data returns.
  assign issue    = running && !pending && (!out_valid || !out_stall);
  assign cur_last = cur_addr == ADDR_W'(MEM_DEPTH - 1);
  assign rd.en    = issue;
  assign rd.addr  = cur_addr;
  assign busy     = running || pending || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (dump_start) begin
        running <= 1'b1;
      end else if (issue && cur_last) begin
        running <= 1'b0;
      end
      pending <= issue;
      if (pending) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dump_start) begin
      cur_addr  <= '0;
      cur_field <= FIELD_TIME;
      cur_pos   <= '0;
    end else if (issue) begin
      cur_addr <= cur_addr + ADDR_W'(1);
      case (cur_field)
        FIELD_TIME: begin
          if (cur_pos == FILL_W'(TIME_LEN - 1)) begin
            cur_field <= FIELD_STATUS;
            cur_pos   <= '0;
          end else begin
            cur_pos <= cur_pos + FILL_W'(1);
          end
        end
        FIELD_STATUS: begin
          cur_field <= FIELD_LAT;
          cur_pos   <= '0;
        end
        FIELD_LAT: begin
          if (cur_pos == FILL_W'(COORD_LEN - 1)) begin
            cur_field <= FIELD_LON;
            cur_pos   <= '0;
          end else begin
            cur_pos <= cur_pos + FILL_W'(1);
          end
        end
        default: cur_pos <= cur_pos + FILL_W'(1);
      endcase
    end
    if (issue) begin
      pend_field <= cur_field;
      pend_pos   <= cur_pos;
      pend_last  <= cur_last;
    end
    if (pending) begin
      field_id   <= pend_field;
      byte_pos   <= 4'(pend_pos);
      char_value <= rdata;
      last       <= pend_last;
    end
  end

endmodule

@@ rtl/core/rmc_sentence_field_extractor.sv @@
// ----------------------------------------------------------------------------
// rmc_sentence_field_extractor
// Extracts time, status, latitude and longitude characters from RMC
// sentences and dumps them as result beats at the end of each sentence.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  char_in
//   output    out        out_valid/out_stall  field_id, byte_pos, char_value, last
//   config    in         APB psel/penable     paddr, pwdata, prdata, pready
//
// A character beat that belongs to a captured field is written straight
// into the field memory at the edge that accepts it. The character that
// ends a sentence starts a dump of all 35 memory entries; the single read
// port of the memory has one read in flight and returns data in the next
// cycle, so a new read is issued only once the last one has returned, and
// output stalls hold the dump. While a dump is in progress in_stall is
// high. Reset is synchronous and clears the sentence state, the dump
// control flags and the per-entry valid bits, so unwritten entries read
// as zero; there is no clearing pass.
//
module rmc_sentence_field_extractor (
  input  logic        clk,
  input  logic        rst,
  // Character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  field_id,
  output logic [3:0]  byte_pos,
  output logic [7:0]  char_value,
  output logic        last,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rsfe_pkg::*;

  logic       accept;
  logic       busy;
  logic       dump_start;
  logic [7:0] type_key;
  logic [7:0] end_char;
  logic [7:0] rdata;
  mem_wr_t    wr;
  mem_rd_t    rd;

  // No character is taken while a dump is running or results are waiting.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign pready   = 1'b1;

  rsfe_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .type_key (type_key),
    .end_char (end_char)
  );

  rsfe_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_in    (char_in),
    .type_key   (type_key),
    .end_char   (end_char),
    .wr         (wr),
    .dump_start (dump_start)
  );

  rsfe_store_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  rsfe_dump u_dump (
    .clk        (clk),
    .rst        (rst),
    .dump_start (dump_start),
    .rd         (rd),
    .rdata      (rdata),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .field_id   (field_id),
    .byte_pos   (byte_pos),
    .char_value (char_value),
    .last       (last)
  );

endmodule

@@ rtl/core/rsfe_checker.sv @@
// ----------------------------------------------------------------------------
// rsfe_checker
// Port-level checks of the RMC sentence field extractor.
// ----------------------------------------------------------------------------
module rsfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] field_id,
  input logic [3:0] byte_pos,
  input logic [7:0] char_value,
  input logic       last
);
  import rsfe_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_id) &&
      $stable(byte_pos) && $stable(char_value) && $stable(last))
    else $error("stalled result beat changed");

  // No further result follows the final beat of a dump.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid)
    else $error("result beat after the final beat of a dump");

  // Input is held off while results are pending.
  a_stall_dump: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a dump is in progress");

  // The status field has a single entry.
  a_status_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_id == FIELD_STATUS |-> byte_pos == 4'd0)
    else $error("status beat with non-zero position");

  // Reset leaves the block idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind rmc_sentence_field_extractor rsfe_checker u_rsfe_checker (.*);
